FILE: hw/rtl/kps_pkg.sv
package kps_pkg;

    localparam int KEY_W     = 48;
    localparam int DBM_W     = 8;
    localparam int EST_W     = 56;
    localparam int VAR_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int NOISE_W   = 32;
    localparam int IN_W      = KEY_W + DBM_W;
    localparam int MANT_W    = 35;
    localparam int BASE_W    = MANT_W + 17;
    localparam int DEND_W    = 64;
    localparam int SOR_W     = 34;
    localparam int OPND_W    = 32;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 88;
    localparam int HALF_W    = 28;
    localparam int ENTRIES_DEFAULT = 128;

    localparam logic [NOISE_W-1:0] NOISE_RESET = 32'h4000_0000;
    localparam logic [VAR_W:0]     ONE_Q31     = 33'h0_8000_0000;
    localparam logic [ACC_W-1:0]   HALF_Q31    = ACC_W'(64'h4000_0000);

    localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DEND_W-1:0] dividend;
        logic [SOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              valid;
        logic              clear;
        logic              shift;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } mac_cmd_t;

    function automatic logic [MANT_W-1:0] dec_mant(input logic [3:0] r);
        logic [MANT_W-1:0] m;
        case (r)
            4'd0:    m = 35'd4294967296;
            4'd1:    m = 35'd5407043472;
            4'd2:    m = 35'd6807064430;
            4'd3:    m = 35'd8569586390;
            4'd4:    m = 35'd10788470075;
            4'd5:    m = 35'd13581879131;
            4'd6:    m = 35'd17098572778;
            4'd7:    m = 35'd21525827778;
            4'd8:    m = 35'd27099411597;
            4'd9:    m = 35'd34116137904;
            default: m = 35'd4294967296;
        endcase
        return m;
    endfunction

    function automatic logic [SOR_W-1:0] pow10(input logic [3:0] n);
        logic [SOR_W-1:0] v;
        case (n)
            4'd0:    v = 34'd1;
            4'd1:    v = 34'd10;
            4'd2:    v = 34'd100;
            4'd3:    v = 34'd1000;
            4'd4:    v = 34'd10000;
            4'd5:    v = 34'd100000;
            4'd6:    v = 34'd1000000;
            4'd7:    v = 34'd10000000;
            4'd8:    v = 34'd100000000;
            4'd9:    v = 34'd1000000000;
            4'd10:   v = 34'd10000000000;
            default: v = 34'd1;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/kps_divider.sv
module kps_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kps_pkg::div_req_t             req,
    output logic                          busy,
    output logic                          done,
    output logic [kps_pkg::DEND_W-1:0]    quotient
);
    import kps_pkg::*;

    logic [DEND_W-1:0] quo_reg, quo_next;
    logic [SOR_W-1:0]  rem_reg, rem_next;
    logic [SOR_W-1:0]  sor_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SOR_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DEND_W-1]};
    assign fits  = trial >= {1'b0, sor_reg};

    always_comb
    begin
        quo_next = {quo_reg[DEND_W-2:0], fits};
        rem_next = fits ? SOR_W'(trial - {1'b0, sor_reg}) : trial[SOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            sor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/kps_mac.sv
module kps_mac
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kps_pkg::mac_cmd_t           cmd,
    output logic [kps_pkg::ACC_W-1:0]   acc
);
    import kps_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              shf_reg;
    logic              pend_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  prod_ext;
    logic [ACC_W-1:0]  addend;

    assign prod_ext = ACC_W'(prod_reg);
    assign addend   = shf_reg ? {prod_ext[ACC_W-HALF_W-1:0], HALF_W'(0)} : prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            prod_reg <= cmd.a * cmd.b;
            shf_reg  <= cmd.shift;
        end
        if (cmd.clear)
        begin
            acc_reg <= HALF_Q31;
        end
        else if (pend_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hw/rtl/per_address_kalman_smoother.sv
// channel   | group    | tdata fields (low bit up)        | tuser
// ----------+----------+----------------------------------+-----------
// input     | s_axis_* | mac_address[47:0], signal_dbm    | -
// output    | m_axis_* | estimate[55:0]                   | status[1:0]
// config    | cfg_wr_* | measurement_noise[31:0]          | -
//
// Search reads the key memory once per stored station (a read state, then a compare state).
// A new or refused station then passes through insert and hand-over.
// An update forms the power and divides it (readings below 0 dBm), forms the gain
// and divides it in the shared divider, then runs the shared multiplier and hands
// the result over.
// Reset clears the fill count and control state but not the stores; they need no clearing pass.
// The input stalls while an item is in work or its result cannot be handed over.
module per_address_kalman_smoother
#(
    parameter int ENTRIES = kps_pkg::ENTRIES_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [kps_pkg::NOISE_W-1:0]     cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kps_pkg::IN_W-1:0]        s_axis_tdata,  // mac_address, signal_dbm
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kps_pkg::EST_W-1:0]       m_axis_tdata,  // estimate
    output logic [kps_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);
    import kps_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ, ST_CMP, ST_INSERT, ST_ZCALC, ST_ZDIV, ST_GAIN, ST_GDIV,
        ST_E0, ST_E1, ST_E2, ST_E3, ST_EW, ST_EC, ST_V0, ST_VW, ST_VC, ST_DONE
    } state_t;

    state_t state_reg;
    logic [NOISE_W-1:0]  noise_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [KEY_W-1:0]    key_reg;
    logic signed [DBM_W-1:0] dbm_reg;
    logic [EST_W-1:0]    x_reg;
    logic [VAR_W-1:0]    p_reg;
    logic [EST_W-1:0]    z_reg;
    logic [VAR_W:0]      k_reg;
    logic [EST_W-1:0]    res_est_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_valid_reg;
    logic [EST_W-1:0]    m_est_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [EST_W-1:0] est_mem [ENTRIES];
    logic [VAR_W-1:0] var_mem [ENTRIES];
    logic [KEY_W-1:0] key_rd_reg;
    logic [EST_W-1:0] est_rd_reg;
    logic [VAR_W-1:0] var_rd_reg;

    logic             mem_we;
    logic             key_we;
    logic [IDX_W-1:0] wr_addr;
    logic [EST_W-1:0] wr_est;
    logic [VAR_W-1:0] wr_var;

    div_req_t          div_req;
    logic              div_busy;
    logic              div_done;
    logic [DEND_W-1:0] div_quo;
    mac_cmd_t          mac_cmd;
    logic [ACC_W-1:0]  mac_acc;

    logic signed [DBM_W-1:0] dbm_sat;
    logic [6:0]        e_val;
    logic [14:0]       e_mul;
    logic [3:0]        q_val;
    logic [3:0]        r_val;
    logic [BASE_W-1:0] base;
    logic [EST_W-1:0]  base_ext;
    logic [SOR_W-1:0]  pdiv;
    logic [VAR_W:0]    den;
    logic [OPND_W-1:0] w_val;
    logic [OPND_W-1:0] k_op;
    logic [EST_W:0]    est_acc;
    logic [EST_W-1:0]  est_new;
    logic              out_free;
    logic              last_entry;

    assign dbm_sat  = (dbm_reg < -8'sd100) ? -8'sd100 : ((dbm_reg > 8'sd20) ? 8'sd20 : dbm_reg);
    assign e_val    = 7'(dbm_sat + 8'sd100);
    assign e_mul    = 15'(e_val) * 15'd205;
    assign q_val    = e_mul[14:11];
    assign r_val    = 4'(e_val - 7'(q_val) * 7'd10);
    assign base     = {dec_mant(r_val), 17'd0};
    assign base_ext = EST_W'(base);
    assign pdiv     = pow10(4'd10 - q_val);
    assign den      = {1'b0, p_reg} + {1'b0, noise_reg};
    assign w_val    = OPND_W'(ONE_Q31 - k_reg);
    assign k_op     = OPND_W'(k_reg);
    assign est_acc  = mac_acc[EST_W+31:31];
    assign est_new  = est_acc[EST_W] ? {EST_W{1'b1}} : est_acc[EST_W-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DEND_W'(base) + DEND_W'(pdiv >> 1);
        div_req.divisor  = pdiv;
        if (state_reg == ST_GAIN)
        begin
            div_req.dividend = DEND_W'({p_reg, 31'd0});
            div_req.divisor  = SOR_W'(den);
            div_req.start    = (den != '0);
        end
        else if (state_reg == ST_ZCALC)
        begin
            div_req.start = (q_val < 4'd10);
        end
    end

    always_comb
    begin
        mac_cmd.valid = 1'b0;
        mac_cmd.clear = (state_reg == ST_GAIN) || (state_reg == ST_EC);
        mac_cmd.shift = 1'b0;
        mac_cmd.a     = w_val;
        mac_cmd.b     = OPND_W'(x_reg[HALF_W-1:0]);
        case (state_reg)
            ST_E0:
            begin
                mac_cmd.valid = 1'b1;
            end
            ST_E1:
            begin
                mac_cmd.valid = 1'b1;
                mac_cmd.shift = 1'b1;
                mac_cmd.b     = OPND_W'(x_reg[EST_W-1:HALF_W]);
            end
            ST_E2:
            begin
                mac_cmd.valid = 1'b1;
                mac_cmd.a     = k_op;
                mac_cmd.b     = OPND_W'(z_reg[HALF_W-1:0]);
            end
            ST_E3:
            begin
                mac_cmd.valid = 1'b1;
                mac_cmd.shift = 1'b1;
                mac_cmd.a     = k_op;
                mac_cmd.b     = OPND_W'(z_reg[EST_W-1:HALF_W]);
            end
            ST_V0:
            begin
                mac_cmd.valid = 1'b1;
                mac_cmd.b     = p_reg;
            end
            default:
            begin
                mac_cmd.valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mem_we  = 1'b0;
        key_we  = 1'b0;
        wr_addr = idx_reg;
        wr_est  = res_est_reg;
        wr_var  = mac_acc[62:31];
        if (state_reg == ST_INSERT && count_reg < CNT_W'(ENTRIES))
        begin
            mem_we  = 1'b1;
            key_we  = 1'b1;
            wr_addr = IDX_W'(count_reg);
            wr_est  = '0;
            wr_var  = ONE_Q31[VAR_W-1:0];
        end
        else if (state_reg == ST_VC)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (mem_we)
        begin
            est_mem[wr_addr] <= wr_est;
            var_mem[wr_addr] <= wr_var;
        end
        key_rd_reg <= key_mem[idx_reg];
        est_rd_reg <= est_mem[idx_reg];
        var_rd_reg <= var_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            noise_reg   <= NOISE_RESET;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                noise_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        key_reg   <= s_axis_tdata[KEY_W-1:0];
                        dbm_reg   <= s_axis_tdata[IN_W-1:KEY_W];
                        idx_reg   <= '0;
                        state_reg <= (count_reg == '0) ? ST_INSERT : ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (key_rd_reg == key_reg)
                    begin
                        x_reg     <= est_rd_reg;
                        p_reg     <= var_rd_reg;
                        state_reg <= ST_ZCALC;
                    end
                    else if (last_entry)
                    begin
                        state_reg <= ST_INSERT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_INSERT:
                begin
                    res_est_reg <= '0;
                    if (count_reg < CNT_W'(ENTRIES))
                    begin
                        count_reg      <= count_reg + CNT_W'(1);
                        res_status_reg <= STATUS_NEW;
                    end
                    else
                    begin
                        res_status_reg <= STATUS_FULL;
                    end
                    state_reg <= ST_DONE;
                end
                ST_ZCALC:
                begin
                    case (q_val)
                        4'd10:   z_reg <= base_ext;
                        4'd11:   z_reg <= (base_ext << 3) + (base_ext << 1);
                        4'd12:   z_reg <= (base_ext << 6) + (base_ext << 5) + (base_ext << 2);
                        default: z_reg <= base_ext;
                    endcase
                    state_reg <= (q_val < 4'd10) ? ST_ZDIV : ST_GAIN;
                end
                ST_ZDIV:
                begin
                    if (div_done)
                    begin
                        z_reg     <= div_quo[EST_W-1:0];
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN:
                begin
                    if (den == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_E0;
                    end
                    else
                    begin
                        state_reg <= ST_GDIV;
                    end
                end
                ST_GDIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= (div_quo > DEND_W'(ONE_Q31)) ? ONE_Q31
                                                                : div_quo[VAR_W:0];
                        state_reg <= ST_E0;
                    end
                end
                ST_E0: state_reg <= ST_E1;
                ST_E1: state_reg <= ST_E2;
                ST_E2: state_reg <= ST_E3;
                ST_E3: state_reg <= ST_EW;
                ST_EW: state_reg <= ST_EC;
                ST_EC:
                begin
                    res_est_reg    <= est_new;
                    res_status_reg <= STATUS_UPDATED;
                    state_reg      <= ST_V0;
                end
                ST_V0: state_reg <= ST_VW;
                ST_VW: state_reg <= ST_VC;
                ST_VC: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_est_reg    <= res_est_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    kps_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    kps_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (mac_acc)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_est_reg;
    assign m_axis_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond table depth");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E0) |-> (k_reg <= ONE_Q31))
        else $error("gain above one");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != STATUS_UNUSED))
        else $error("reserved status code");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (div_busy || mac_cmd.valid) |-> !s_axis_tready)
        else $error("input ready during arithmetic");

endmodule

FILE: verif/per_address_kalman_smoother_tb.sv
`timescale 1ns / 100ps

module per_address_kalman_smoother_tb;
    import kps_pkg::*;

    localparam int TABLE_DEPTH = ENTRIES_DEFAULT;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int POOL_SIZE   = 24;

    typedef struct {
        logic [KEY_W-1:0]        mac;
        logic signed [DBM_W-1:0] dbm;
    } reading_t;

    typedef struct {
        logic [EST_W-1:0]    estimate;
        logic [STATUS_W-1:0] status;
    } smoothed_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [NOISE_W-1:0]   cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [EST_W-1:0]     m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    per_address_kalman_smoother dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    reading_t  pending_readings[$];
    smoothed_t expected_smoothed[$];
    int        failures;
    int        cycle_count;
    int        readings_sent;
    int        results_checked;
    int        status_seen[3];
    logic      s_axis_tready_seen;

    logic [KEY_W-1:0] pool[POOL_SIZE];

    logic [NOISE_W-1:0] noise_var;
    logic               station_valid[TABLE_DEPTH];
    logic [KEY_W-1:0]   station_key[TABLE_DEPTH];
    logic [EST_W-1:0]   station_power[TABLE_DEPTH];
    logic [VAR_W-1:0]   station_var[TABLE_DEPTH];

    const logic [63:0] mantissa[10] = '{
        64'd4294967296, 64'd5407043472, 64'd6807064430, 64'd8569586390,
        64'd10788470075, 64'd13581879131, 64'd17098572778, 64'd21525827778,
        64'd27099411597, 64'd34116137904
    };

    function automatic logic [63:0] decade(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++)
            v = v * 64'd10;
        return v;
    endfunction

    function automatic logic [63:0] linear_power(input logic signed [DBM_W-1:0] dbm);
        int          d;
        int          q;
        int          r;
        logic [63:0] base;
        logic [63:0] div;
        d = int'(dbm);
        if (d < -100)
            d = -100;
        if (d > 20)
            d = 20;
        q = (d + 100) / 10;
        r = (d + 100) % 10;
        base = mantissa[r] << 17;
        if (q >= 10)
            return base * decade(q - 10);
        div = decade(10 - q);
        return (base + div / 2) / div;
    endfunction

    function automatic smoothed_t smooth_reading(input reading_t rd);
        smoothed_t    res;
        logic [32:0]  den;
        logic [95:0]  gain;
        logic [95:0]  w;
        logic [127:0] acc;
        logic [63:0]  z;
        int           free_slot;
        free_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (station_valid[i] && station_key[i] == rd.mac)
            begin
                z = linear_power(rd.dbm);
                den = {1'b0, station_var[i]} + {1'b0, noise_var};
                if (den == '0)
                    gain = '0;
                else
                    gain = ({64'd0, station_var[i]} << 31) / den;
                if (gain > 96'h8000_0000)
                    gain = 96'h8000_0000;
                w = 96'h8000_0000 - gain;
                acc = w * station_power[i] + gain * z + 128'h4000_0000;
                acc = acc >> 31;
                if (acc > {72'd0, {EST_W{1'b1}}})
                    acc = {72'd0, {EST_W{1'b1}}};
                station_power[i] = acc[EST_W-1:0];
                acc = w * station_var[i] + 128'h4000_0000;
                station_var[i] = acc[62:31];
                res.estimate = station_power[i];
                res.status = STATUS_UPDATED;
                return res;
            end
            if (!station_valid[i] && free_slot < 0)
                free_slot = i;
        end
        res.estimate = '0;
        if (free_slot >= 0)
        begin
            station_valid[free_slot] = 1'b1;
            station_key[free_slot] = rd.mac;
            station_power[free_slot] = '0;
            station_var[free_slot] = 32'h8000_0000;
            res.status = STATUS_NEW;
        end
        else
            res.status = STATUS_FULL;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [KEY_W-1:0] random_mac();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic reading_t random_reading(input int fresh_pct);
        reading_t rd;
        if ($urandom_range(0, 99) < fresh_pct)
            rd.mac = random_mac();
        else
            rd.mac = pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 99) < 70)
            rd.dbm = DBM_W'($urandom_range(0, 140) - 110);
        else
            rd.dbm = DBM_W'($urandom_range(0, 255));
        return rd;
    endfunction

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // driver
    int source_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            source_gap    = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready_seen)
        begin
            if (source_gap > 0 || pending_readings.size() == 0)
            begin
                if (source_gap > 0)
                    source_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                reading_t rd;
                rd = pending_readings.pop_front();
                s_axis_tdata  <= {rd.dbm, rd.mac};
                s_axis_tvalid <= 1'b1;
                readings_sent++;
                source_gap = pick_gap();
            end
        end
    end

    int sink_stall;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    = 0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tready_seen <= 1'b0;
        else
        begin
            s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                reading_t rd;
                rd.mac = s_axis_tdata[KEY_W-1:0];
                rd.dbm = s_axis_tdata[IN_W-1:KEY_W];
                expected_smoothed.push_back(smooth_reading(rd));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                smoothed_t want;
                if (expected_smoothed.size() == 0)
                begin
                    $error("result with nothing expected: estimate %h status %0d",
                           m_axis_tdata, m_axis_tuser);
                    failures++;
                end
                else
                begin
                    want = expected_smoothed.pop_front();
                    results_checked++;
                    if (want.status < 3)
                        status_seen[want.status]++;
                    if (m_axis_tdata !== want.estimate)
                    begin
                        $error("estimate: expected %h, got %h", want.estimate, m_axis_tdata);
                        failures++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_readings.size() != 0 || s_axis_tvalid || expected_smoothed.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_noise(input logic [NOISE_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        noise_var = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic queue_reading(input logic [KEY_W-1:0] mac, input int dbm);
        reading_t rd;
        rd.mac = mac;
        rd.dbm = DBM_W'(dbm);
        pending_readings.push_back(rd);
    endtask

    task automatic queue_random(input int count, input int fresh_pct);
        for (int i = 0; i < count; i++)
            pending_readings.push_back(random_reading(fresh_pct));
    endtask

    initial
    begin
        failures = 0;
        cycle_count = 0;
        readings_sent = 0;
        results_checked = 0;
        status_seen = '{0, 0, 0};
        noise_var = NOISE_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            station_valid[i] = 1'b0;
            station_key[i] = '0;
            station_power[i] = '0;
            station_var[i] = '0;
        end
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            pool[i] = random_mac();
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_reading(pool[0], 0);
        queue_reading(pool[0], -128);
        queue_reading(pool[0], 127);
        queue_reading(pool[0], -100);
        queue_reading(pool[0], -101);
        queue_reading(pool[0], 20);
        queue_reading(pool[0], 21);
        queue_reading(pool[0], -1);
        queue_reading(pool[0], -55);
        queue_reading(pool[0], 9);
        queue_reading(pool[1], 127);
        queue_reading(pool[1], 20);
        queue_reading(pool[1], -128);
        queue_reading(pool[1], 19);
        queue_reading(pool[2], -91);
        queue_reading(pool[2], -90);
        queue_reading(pool[1], 0);
        queue_random(400, 4);

        write_noise(32'd1);
        queue_random(400, 10);

        write_noise(32'hFFFF_FFFF);
        queue_random(400, 15);

        write_noise($urandom_range(1, 32'hFFFF_FFFE));
        queue_random(400, 15);

        write_noise(32'd1);
        queue_random(300, 10);

        wait_drained();
        repeat (500) @(posedge clk);

        $display("Sent %0d readings, checked %0d results over five noise settings.",
                 readings_sent, results_checked);
        $display("Outcomes: %0d updates, %0d new stations, %0d refused as full.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (failures == 0 && expected_smoothed.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/kps_pkg.sv
hw/rtl/kps_divider.sv
hw/rtl/kps_mac.sv
hw/rtl/per_address_kalman_smoother.sv
verif/per_address_kalman_smoother_tb.sv
